// ----- design/assert_macros.svh -----
// assertion macros used by the sensor frame checker design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- design/sfcd_pkg.sv -----
// types, constants and the crc step for the sensor frame checker
`timescale 1ns / 1ps
package sfcd_pkg;

  localparam int unsigned SP_LEN      = 9;
  localparam int unsigned ROM_LEN     = 8;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned TEMP_W      = 19;
  localparam int unsigned ID_W        = 64;
  localparam int unsigned PROD_W      = 23;
  localparam int unsigned OUT_DATA_W  = 88;
  localparam logic [7:0]  CRC_POLY    = 8'h8C;
  localparam logic [PROD_W-1:0] CENTI_PER_DEG = PROD_W'(100);
  localparam logic [PROD_W-1:0] LSB_ROUND     = PROD_W'(15);

  // frame type codes
  localparam logic KIND_SP  = 1'b0;
  localparam logic KIND_ROM = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_ALL_ZERO = 2'd2
  } status_t;

  // one byte of the reflected crc-8, lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       mix;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ b[i];
      c   = {1'b0, c[7:1]} ^ (mix ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

endpackage

// ----- design/sensor_frame_check_decode.sv -----
// checker and decoder for scratchpad and rom frames read from a sensor bus
`timescale 1ns / 1ps
// Takes one bus byte per transaction and accepts a new one every cycle as long as
// results are taken. Each byte is held in an input register, then the crc, byte
// counter and captured fields update and, at the last byte of a frame (ninth of a
// scratchpad, eighth of a rom frame), the result goes to an output register. The
// output register is the only place that stalls the input side. Bytes after the
// end of a frame give nothing; frame_start drops an unfinished frame.
// temperature_centi is set only for a scratchpad with status ok, rom_id only for a
// rom frame with status ok.
module sensor_frame_check_decode (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // data_byte
  input  logic [1:0]                         in_tuser,   // kind, frame_start
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sfcd_pkg::OUT_DATA_W-1:0]    out_tdata,  // status, temperature_centi,
                                                         // rom_id, zero pad
  output logic [0:0]                         out_tuser   // frame_kind
);
  import sfcd_pkg::*;

  // input register
  logic       s1_valid_r;
  logic       s1_kind_r;
  logic       s1_start_r;
  logic [7:0] s1_byte_r;

  // frame state
  logic [7:0]       crc_r,   crc_nxt;
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  logic             type_r,  type_nxt;
  logic [7:0]       tlow_r,  tlow_nxt;
  logic [7:0]       thigh_r, thigh_nxt;
  logic             zeros_r, zeros_nxt;
  logic [ID_W-1:0]  id_r,    id_nxt;

  // result register
  logic              out_valid_r;
  logic              out_kind_r,   out_kind_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [TEMP_W-1:0] out_temp_r,   out_temp_nxt;
  logic [ID_W-1:0]   out_id_r,     out_id_nxt;

  logic             advance;
  logic             last_byte;
  logic             active;
  logic [7:0]       crc_eff;
  logic [CNT_W-1:0] pos;
  logic             type_eff;
  logic [7:0]       tlow_eff;
  logic [7:0]       thigh_eff;
  logic             zeros_eff;
  logic [ID_W-1:0]  id_eff;
  logic [CNT_W-1:0] len;
  logic [PROD_W-1:0] raw_ext;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] biased;

  // handshake
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // state seen by this byte, a frame start begins from a fresh frame
  always_comb begin
    if (s1_start_r) begin
      crc_eff   = 8'h00;
      pos       = '0;
      type_eff  = s1_kind_r;
      tlow_eff  = 8'h00;
      thigh_eff = 8'h00;
      zeros_eff = 1'b1;
      id_eff    = '0;
    end else begin
      crc_eff   = crc_r;
      pos       = cnt_r;
      type_eff  = type_r;
      tlow_eff  = tlow_r;
      thigh_eff = thigh_r;
      zeros_eff = zeros_r;
      id_eff    = id_r;
    end
    len       = (type_eff == KIND_ROM) ? CNT_W'(ROM_LEN) : CNT_W'(SP_LEN);
    active    = pos < len;
    last_byte = active && (pos == len - CNT_W'(1));
  end

  // next frame state
  always_comb begin
    crc_nxt   = crc_eff;
    cnt_nxt   = pos;
    type_nxt  = type_eff;
    tlow_nxt  = tlow_eff;
    thigh_nxt = thigh_eff;
    zeros_nxt = zeros_eff;
    id_nxt    = id_eff;
    if (active) begin
      cnt_nxt   = pos + CNT_W'(1);
      zeros_nxt = zeros_eff && (s1_byte_r == 8'h00);
      for (int k = 0; k < int'(ROM_LEN); k++) begin
        if (pos == CNT_W'(k)) id_nxt[k*8 +: 8] = s1_byte_r;
      end
      if (type_eff == KIND_SP && pos == CNT_W'(0)) tlow_nxt  = s1_byte_r;
      if (type_eff == KIND_SP && pos == CNT_W'(1)) thigh_nxt = s1_byte_r;
      if (!last_byte) crc_nxt = crc8_byte(crc_eff, s1_byte_r);
    end
  end

  // temperature: raw * 100 / 16, truncated toward zero
  always_comb begin
    raw_ext = {{(PROD_W-16){thigh_eff[7]}}, thigh_eff, tlow_eff};
    prod    = PROD_W'($signed(raw_ext) * $signed(CENTI_PER_DEG));
    biased  = prod + (prod[PROD_W-1] ? LSB_ROUND : '0);
  end

  // result fields
  always_comb begin
    out_kind_nxt   = type_eff;
    out_status_nxt = ST_OK;
    out_temp_nxt   = '0;
    out_id_nxt     = '0;
    priority if (crc_eff != s1_byte_r) begin
      out_status_nxt = ST_CRC_ERR;
    end else if (type_eff == KIND_ROM) begin
      out_id_nxt = id_nxt;
    end else if (zeros_nxt) begin
      out_status_nxt = ST_ALL_ZERO;
    end else begin
      out_temp_nxt = biased[PROD_W-1:PROD_W-TEMP_W];
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= 8'h00;
      cnt_r       <= '0;
      type_r      <= KIND_SP;
      tlow_r      <= 8'h00;
      thigh_r     <= 8'h00;
      zeros_r     <= 1'b1;
      id_r        <= '0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (advance) begin
        crc_r   <= crc_nxt;
        cnt_r   <= cnt_nxt;
        type_r  <= type_nxt;
        tlow_r  <= tlow_nxt;
        thigh_r <= thigh_nxt;
        zeros_r <= zeros_nxt;
        id_r    <= id_nxt;
      end
      if (advance && last_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_kind_r  <= in_tuser[0];
      s1_start_r <= in_tuser[1];
      s1_byte_r  <= in_tdata;
    end
    if (advance && last_byte) begin
      out_kind_r   <= out_kind_nxt;
      out_status_r <= out_status_nxt;
      out_temp_r   <= out_temp_nxt;
      out_id_r     <= out_id_nxt;
    end
  end

  // outputs
  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_kind_r;
  assign out_tdata    = {{(OUT_DATA_W-ID_W-TEMP_W-2){1'b0}}, out_id_r, out_temp_r,
                         out_status_r};

`include "assert_macros.svh"

  `ASSERT_CLK(a_cnt_range, cnt_r <= CNT_W'(SP_LEN), "byte counter past frame length")
  `ASSERT_CLK(a_rom_no_zero, out_valid_r && out_kind_r == KIND_ROM |-> out_status_r != ST_ALL_ZERO, "rom frame flagged all-zero")
  `ASSERT_CLK(a_err_fields, out_valid_r && out_status_r != ST_OK |-> out_temp_r == '0 && out_id_r == '0, "fields set on failed frame")
  `ASSERT_CLK(a_ready_empty, !out_valid_r |-> in_tready, "input stalled with empty output")
  `ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid_r && !s1_valid_r, "valid after reset")

endmodule

// ----- sim/frame_checker.sv -----
// frame decode predictor and result checker for the sensor frame checker
`timescale 1ns / 1ps

package frame_crc_pkg;

  // reflected crc-8 over one byte, byte folded in first
  function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[0] ? ((c >> 1) ^ sfcd_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

endpackage

module frame_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // data_byte
  input  logic [1:0]                      in_tuser,   // kind, frame_start
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [sfcd_pkg::OUT_DATA_W-1:0] out_tdata,  // status, temperature_centi, rom_id
  input  logic [0:0]                      out_tuser,  // frame_kind
  output int                              errors,
  output int                              pending
);
  import sfcd_pkg::*;
  import frame_crc_pkg::*;

  typedef struct packed {
    logic               kind;
    status_t            status;
    logic signed [18:0] centi;
    logic [63:0]        id;
  } frame_result_t;

  frame_result_t expected_q[$];

  // decoder state mirrored from the outside
  logic [7:0]  crc_run;
  logic [3:0]  nbytes;
  logic        ftype;
  logic [7:0]  t_lo;
  logic [7:0]  t_hi;
  logic        all_zero;
  logic [63:0] id_run;

  task automatic clear_frame(input logic kind);
    crc_run  = '0;
    nbytes   = '0;
    ftype    = kind;
    t_lo     = '0;
    t_hi     = '0;
    all_zero = 1'b1;
    id_run   = '0;
  endtask

  // fold one accepted byte into the frame, queue a result at the frame end
  task automatic decode_byte(input logic kind, input logic [7:0] b, input logic start);
    int unsigned        flen;
    int unsigned        pos;
    logic signed [15:0] raw;
    int                 scaled;
    frame_result_t      r;
    if (start) clear_frame(kind);
    flen = (ftype == KIND_ROM) ? ROM_LEN : SP_LEN;
    pos  = nbytes;
    if (pos >= flen) return;
    if (b != 8'h00) all_zero = 1'b0;
    if (pos < ROM_LEN) id_run[8*pos +: 8] = b;
    if (ftype == KIND_SP && pos == 0) t_lo = b;
    if (ftype == KIND_SP && pos == 1) t_hi = b;
    nbytes = 4'(pos + 1);
    if (pos + 1 < flen) begin
      crc_run = crc8_update(crc_run, b);
      return;
    end
    // last byte carries the crc
    r.kind  = ftype;
    r.centi = '0;
    r.id    = '0;
    if (crc_run != b) begin
      r.status = ST_CRC_ERR;
    end else if (ftype == KIND_ROM) begin
      r.status = ST_OK;
      r.id     = id_run;
    end else if (all_zero) begin
      r.status = ST_ALL_ZERO;
    end else begin
      raw      = {t_hi, t_lo};
      scaled   = (int'(raw) * 100) / 16;
      r.status = ST_OK;
      r.centi  = scaled[18:0];
    end
    expected_q.push_back(r);
  endtask

  // compare one result against the oldest expectation
  task automatic check_result();
    frame_result_t want;
    frame_result_t got;
    got.kind   = out_tuser[0];
    got.status = status_t'(out_tdata[1:0]);
    got.centi  = out_tdata[20:2];
    got.id     = out_tdata[84:21];
    if (expected_q.size() == 0) begin
      $display("%0t: result with nothing expected: kind %0d status %0d temp %0d id %h",
               $time, got.kind, got.status, got.centi, got.id);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got != want) begin
      errors++;
      if (got.kind != want.kind)
        $display("%0t: frame_kind expected %0d actual %0d", $time, want.kind, got.kind);
      if (got.status != want.status)
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      if (got.centi != want.centi)
        $display("%0t: temperature_centi expected %0d actual %0d", $time, want.centi,
                 got.centi);
      if (got.id != want.id)
        $display("%0t: rom_id expected %h actual %h", $time, want.id, got.id);
    end
  endtask

  // watch both channels on every rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame(KIND_SP);
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) decode_byte(in_tuser[0], in_tdata, in_tuser[1]);
    end
    pending = expected_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
// stimulus, clock, reset and verdict for the sensor frame checker
`timescale 1ns / 1ps

module testbench;
  import sfcd_pkg::*;
  import frame_crc_pkg::*;

  localparam int BYTE_TARGET = 700;
  localparam int QUIET_FROM  = 600;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [15:0] EXTREME_RAW [4] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001};

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;

  int       errors;
  int       pending;
  int       sent = 0;
  int       cycles = 0;
  bit       idle_off = 1'b0;
  logic [7:0] frame_bytes[$];

  sensor_frame_check_decode dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  frame_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side stalls in bursts
  initial begin
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && !idle_off && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 5);
      out_tready <= (stall == 0);
      if (stall > 0) stall--;
    end
  end

  // one byte transaction, then maybe an idle burst
  task automatic send_byte(input logic [7:0] b, input logic kind, input logic start);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= {start, kind};
    do @(posedge clk); while (!in_tready);
    sent++;
    if (!idle_off && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 2'($urandom);
      repeat ($urandom_range(1, 5) - 1) @(negedge clk);
    end
  endtask

  // append the frame crc, optionally damaged
  task automatic add_crc(input bit corrupt);
    logic [7:0] c;
    c = 8'h00;
    foreach (frame_bytes[i]) c = crc8_update(c, frame_bytes[i]);
    if (corrupt) c ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(c);
  endtask

  // start flag on the first byte, kind toggles freely inside the frame
  task automatic send_frame(input logic kind);
    foreach (frame_bytes[i]) begin
      if (i == 0) send_byte(frame_bytes[i], kind, 1'b1);
      else send_byte(frame_bytes[i], 1'($urandom), 1'b0);
    end
  endtask

  // well-formed frame with random content, some damaged, cut short or followed by junk
  task automatic random_frame();
    logic        k;
    int unsigned flen;
    int unsigned sel;
    int unsigned cut;
    logic [15:0] t;
    k    = 1'($urandom);
    flen = (k == KIND_ROM) ? ROM_LEN : SP_LEN;
    sel  = $urandom_range(0, 9);
    frame_bytes.delete();
    for (int i = 0; i < flen - 1; i++) frame_bytes.push_back(sel == 0 ? 8'h00 : 8'($urandom));
    if (k == KIND_SP && sel == 1) begin
      t = EXTREME_RAW[$urandom_range(0, 3)];
      frame_bytes[0] = t[7:0];
      frame_bytes[1] = t[15:8];
    end
    add_crc($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, flen - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    send_frame(k);
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'($urandom), 1'b0);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // all-zero scratchpad before any start flag
    repeat (SP_LEN) send_byte(8'h00, 1'($urandom), 1'b0);
    // byte after the frame end is ignored
    send_byte(8'hA5, KIND_ROM, 1'b0);
    // rom frame with good crc
    frame_bytes = '{8'h28, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    add_crc(1'b0);
    send_frame(KIND_ROM);
    // scratchpad dropped by a restart
    frame_bytes = '{8'h50, 8'h05};
    send_frame(KIND_SP);
    // most negative temperature
    frame_bytes = '{8'h00, 8'h80, 8'h4B, 8'h46, 8'h7F, 8'hFF, 8'h0C, 8'h10};
    add_crc(1'b0);
    send_frame(KIND_SP);

    // drain before the random part
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);

    while (sent < BYTE_TARGET) begin
      if (sent >= QUIET_FROM) idle_off = 1'b1;
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'($urandom), 1'($urandom));
      else
        random_frame();
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
